FILE: src/fsp_pkg.sv
// ----------------------------------------------------------------------------
// fsp_pkg
// Shared types and constants for the float literal prefix scanner: word
// formats, character classes, scan phases and status codes.
// ----------------------------------------------------------------------------
package fsp_pkg;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [7:0] char_code;
    logic       at_end;
  } in_word_t;

  typedef struct packed {
    logic       consumed;
    logic [1:0] scan_status;
    logic       give_back;
  } out_word_t;

  typedef enum logic [2:0] {
    CL_DIGIT,
    CL_SIGN,
    CL_POINT,
    CL_EXP,
    CL_OTHER,
    CL_END
  } char_class_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_AFTER_SIGN,
    PH_MANTISSA,
    PH_AFTER_E,
    PH_EXP_SIGN,
    PH_EXP_DIGITS
  } phase_t;

  typedef enum logic [1:0] {
    ST_SCANNING,
    ST_ACCEPT,
    ST_REJECT,
    ST_EMPTY
  } status_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic        valid;
    char_class_t cls;
  } q_head_t;

  function automatic char_class_t classify(input logic [7:0] c, input logic at_end);
    char_class_t cl;
    if (at_end) begin
      cl = CL_END;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      cl = CL_DIGIT;
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      cl = CL_SIGN;
    end else if (c == CH_POINT) begin
      cl = CL_POINT;
    end else if (c == CH_E_LO || c == CH_E_UP) begin
      cl = CL_EXP;
    end else begin
      cl = CL_OTHER;
    end
    return cl;
  endfunction

endpackage

FILE: src/float_literal_prefix_scanner.sv
// ----------------------------------------------------------------------------
// float_literal_prefix_scanner
// Recognizes the longest decimal floating-point literal prefix of a
// character stream, one character word in, one result word out.
// ----------------------------------------------------------------------------
// Usage:
//   in_data carries one character (or the end-of-stream mark in at_end).
//   out_data reports for that character whether it was consumed, the scan
//   status (scanning, accepted, rejected, rejected on empty stream) and
//   whether the last sign, point or exponent letter goes back to the stream.
//   Every accepted input word yields exactly one result word, in order.
//   A word passes through the class queue and then the result register.
//   Throughput: one word per cycle while out_stall is low; the scan state
//   machine updates once per character and its next state depends on the
//   current class, the scan phase and the seen point and digit flags.
//   A two-entry class queue sits between the classifier and the state
//   machine; in_stall rises only when that queue is full. While out_stall
//   is high and a result word waits, the result register holds it and the
//   state machine waits.
//   Reset (rst_n low, synchronous) empties the queue and the result
//   register and returns the scan to start of number.
// ----------------------------------------------------------------------------
module float_literal_prefix_scanner (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fsp_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output fsp_pkg::out_word_t out_data
);
  import fsp_pkg::*;

  q_head_t q_head;
  logic    q_pop;

  fsp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  fsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: src/fsp_front.sv
// ----------------------------------------------------------------------------
// fsp_front
// Input side: classifies each character word and holds the class in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module fsp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  fsp_pkg::in_word_t in_data,
  output fsp_pkg::q_head_t  q_head,
  input  logic              q_pop
);
  import fsp_pkg::*;

  char_class_t q_mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push, pop;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && (cnt_r != 2'd0);

  assign q_head.valid = (cnt_r != 2'd0);
  assign q_head.cls   = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= classify(in_data.char_code, in_data.at_end);
    end
  end

endmodule

FILE: src/fsp_back.sv
// ----------------------------------------------------------------------------
// fsp_back
// Scan state machine: takes one class per cycle from the queue unless a
// stalled result waits; sets the literal phase and the registered result word.
// ----------------------------------------------------------------------------
module fsp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  fsp_pkg::q_head_t   q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output fsp_pkg::out_word_t out_data
);
  import fsp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic        seen_point_r, seen_point_nxt;
  logic        seen_digit_r, seen_digit_nxt;
  logic        out_valid_r;
  out_word_t   out_data_r;

  char_class_t cls;
  logic        take;
  status_t     status;
  logic        back;
  logic        m_point, m_digit;

  assign cls   = q_head.cls;
  assign q_pop = q_head.valid && (!out_valid_r || !out_stall);

  // flags that apply in mantissa evaluation: a fresh scan starts them clear
  assign m_point = (phase_r == PH_MANTISSA) ? seen_point_r : 1'b0;
  assign m_digit = (phase_r == PH_MANTISSA) ? seen_digit_r : 1'b0;

  // result of the current class
  always_comb begin
    take   = 1'b0;
    status = ST_SCANNING;
    back   = 1'b0;
    case (phase_r)
      PH_AFTER_SIGN: begin
        if (cls == CL_DIGIT || cls == CL_POINT) begin
          take = 1'b1;
        end else begin
          status = ST_REJECT;
          back   = 1'b1;
        end
      end
      PH_AFTER_E: begin
        if (cls == CL_DIGIT || cls == CL_SIGN) begin
          take = 1'b1;
        end else begin
          status = ST_ACCEPT;
          back   = 1'b1;
        end
      end
      PH_EXP_SIGN: begin
        if (cls == CL_DIGIT) begin
          take = 1'b1;
        end else begin
          status = ST_REJECT;
          back   = 1'b1;
        end
      end
      PH_EXP_DIGITS: begin
        if (cls == CL_DIGIT) begin
          take = 1'b1;
        end else begin
          status = ST_ACCEPT;
        end
      end
      default: begin
        if (phase_r != PH_MANTISSA && cls == CL_END) begin
          status = ST_EMPTY;
        end else if (phase_r != PH_MANTISSA && cls == CL_SIGN) begin
          take = 1'b1;
        end else if (cls == CL_DIGIT) begin
          take = 1'b1;
        end else if (cls == CL_POINT && !m_point) begin
          take = 1'b1;
        end else if (!m_digit) begin
          status = ST_REJECT;
          back   = m_point;
        end else if (cls == CL_EXP) begin
          take = 1'b1;
        end else begin
          status = ST_ACCEPT;
        end
      end
    endcase
  end

  // next scan state
  always_comb begin
    phase_nxt      = phase_r;
    seen_point_nxt = seen_point_r;
    seen_digit_nxt = seen_digit_r;
    if (status != ST_SCANNING) begin
      phase_nxt      = PH_START;
      seen_point_nxt = 1'b0;
      seen_digit_nxt = 1'b0;
    end else begin
      case (phase_r)
        PH_AFTER_SIGN: begin
          phase_nxt = PH_MANTISSA;
          if (cls == CL_DIGIT) begin
            seen_digit_nxt = 1'b1;
          end else begin
            seen_point_nxt = 1'b1;
          end
        end
        PH_AFTER_E: begin
          phase_nxt = (cls == CL_DIGIT) ? PH_EXP_DIGITS : PH_EXP_SIGN;
        end
        PH_EXP_SIGN: begin
          phase_nxt = PH_EXP_DIGITS;
        end
        PH_EXP_DIGITS: begin
          phase_nxt = PH_EXP_DIGITS;
        end
        default: begin
          seen_point_nxt = m_point;
          seen_digit_nxt = m_digit;
          if (phase_r != PH_MANTISSA && cls == CL_SIGN) begin
            phase_nxt      = PH_AFTER_SIGN;
            seen_point_nxt = 1'b0;
            seen_digit_nxt = 1'b0;
          end else if (cls == CL_DIGIT) begin
            phase_nxt      = PH_MANTISSA;
            seen_digit_nxt = 1'b1;
          end else if (cls == CL_POINT) begin
            phase_nxt      = PH_MANTISSA;
            seen_point_nxt = 1'b1;
          end else begin
            phase_nxt = PH_AFTER_E;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_START;
      seen_point_r <= 1'b0;
      seen_digit_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r      <= phase_nxt;
        seen_point_r <= seen_point_nxt;
        seen_digit_r <= seen_digit_nxt;
        out_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r.consumed    <= take;
      out_data_r.scan_status <= status;
      out_data_r.give_back   <= back;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_end_not_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.scan_status != ST_SCANNING |-> !out_data_r.consumed)
    else $error("result word ends a scan but marks the character consumed");

  a_give_back_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.give_back |-> out_data_r.scan_status != ST_SCANNING)
    else $error("give_back set while still scanning");

  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && status != ST_SCANNING |=> phase_r == PH_START && !seen_point_r && !seen_digit_r)
    else $error("scan end did not return to start of number");

  a_pop_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid_r)
    else $error("popped class produced no result word");

endmodule

FILE: tb/float_literal_prefix_scanner_test.sv
// ----------------------------------------------------------------------------
// float_literal_prefix_scanner_test
// Checks the scanner against a scan-state predictor, one result word per
// character word. Directed literals and corner cases come first, then random
// literals mixed with noise. Both sides idle in random bursts, and the
// receiver holds off once long enough to fill the block and stall its input.
// ----------------------------------------------------------------------------
module float_literal_prefix_scanner_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fsp_pkg::*;

  localparam int RANDOM_CHARS = 1100;
  localparam int TAIL_CHARS   = 150;
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 80;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  in_word_t  pending_chars[$];
  out_word_t expected_results[$];
  int        chars_sent = 0;
  int        mismatch_cnt = 0;
  int        send_gap = 0;
  int        stall_left = 0;
  logic      long_hold = 1'b0;

  phase_t    scan_ph = PH_START;
  logic      frac_point_seen = 1'b0;
  logic      mant_digit_seen = 1'b0;

  float_literal_prefix_scanner dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Advances the scan state by one character word and returns its result.
  function automatic out_word_t scan_char(in_word_t w);
    logic      dig, sgn, pnt, expl;
    logic      take, back;
    status_t   st;
    out_word_t r;
    dig  = !w.at_end && w.char_code >= CH_ZERO && w.char_code <= CH_NINE;
    sgn  = !w.at_end && (w.char_code == CH_PLUS || w.char_code == CH_MINUS);
    pnt  = !w.at_end && w.char_code == CH_POINT;
    expl = !w.at_end && (w.char_code == CH_E_LO || w.char_code == CH_E_UP);
    take = 1'b0;
    back = 1'b0;
    st   = ST_SCANNING;
    case (scan_ph)
      PH_AFTER_SIGN: begin
        if (dig) begin
          take = 1'b1; mant_digit_seen = 1'b1; scan_ph = PH_MANTISSA;
        end else if (pnt) begin
          take = 1'b1; frac_point_seen = 1'b1; scan_ph = PH_MANTISSA;
        end else begin
          st = ST_REJECT; back = 1'b1;
        end
      end
      PH_AFTER_E: begin
        if (dig) begin
          take = 1'b1; scan_ph = PH_EXP_DIGITS;
        end else if (sgn) begin
          take = 1'b1; scan_ph = PH_EXP_SIGN;
        end else begin
          st = ST_ACCEPT; back = 1'b1;
        end
      end
      PH_EXP_SIGN: begin
        if (dig) begin
          take = 1'b1; scan_ph = PH_EXP_DIGITS;
        end else begin
          st = ST_REJECT; back = 1'b1;
        end
      end
      PH_EXP_DIGITS: begin
        if (dig) take = 1'b1;
        else st = ST_ACCEPT;
      end
      default: begin
        if (scan_ph != PH_MANTISSA && w.at_end) begin
          st = ST_EMPTY;
        end else if (scan_ph != PH_MANTISSA && sgn) begin
          take = 1'b1; frac_point_seen = 1'b0; mant_digit_seen = 1'b0;
          scan_ph = PH_AFTER_SIGN;
        end else begin
          if (scan_ph != PH_MANTISSA) begin
            frac_point_seen = 1'b0; mant_digit_seen = 1'b0; scan_ph = PH_MANTISSA;
          end
          if (dig) begin
            take = 1'b1; mant_digit_seen = 1'b1;
          end else if (pnt && !frac_point_seen) begin
            take = 1'b1; frac_point_seen = 1'b1;
          end else if (!mant_digit_seen) begin
            st = ST_REJECT; back = frac_point_seen;
          end else if (expl) begin
            take = 1'b1; scan_ph = PH_AFTER_E;
          end else begin
            st = ST_ACCEPT;
          end
        end
      end
    endcase
    if (st != ST_SCANNING) begin
      scan_ph = PH_START; frac_point_seen = 1'b0; mant_digit_seen = 1'b0;
    end
    r.consumed    = take;
    r.scan_status = st;
    r.give_back   = back;
    return r;
  endfunction

  task automatic push_char(logic [7:0] c);
    in_word_t w;
    w.char_code = c;
    w.at_end    = 1'b0;
    pending_chars.push_back(w);
  endtask

  task automatic push_end(logic [7:0] c);
    in_word_t w;
    w.char_code = c;
    w.at_end    = 1'b1;
    pending_chars.push_back(w);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  task automatic push_digits(int n);
    repeat (n) push_char(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic push_sign();
    push_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
  endtask

  // Mostly well-formed literal with random content and a random terminator.
  task automatic push_literal();
    if ($urandom_range(0, 2) == 0) push_sign();
    push_digits($urandom_range(0, 4));
    if ($urandom_range(0, 1)) push_char(CH_POINT);
    push_digits($urandom_range(0, 3));
    if ($urandom_range(0, 1)) begin
      push_char($urandom_range(0, 1) ? CH_E_LO : CH_E_UP);
      if ($urandom_range(0, 1)) push_sign();
      push_digits($urandom_range(0, 3));
    end
    case ($urandom_range(0, 3))
      0: push_end(8'($urandom_range(0, 255)));
      1: begin
        case ($urandom_range(0, 3))
          0: push_char(CH_POINT);
          1: push_char(CH_E_UP);
          2: push_char(CH_E_LO);
          default: push_sign();
        endcase
      end
      default: push_char(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  // Driver: holds the word while stalled, otherwise idles or presents the next.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(scan_char(in_data));
        chars_sent <= chars_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_chars.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_chars.size() > TAIL_CHARS && !long_hold &&
                     $urandom_range(0, 5) == 0) begin
          in_valid <= 1'b0;
          send_gap <= $urandom_range(0, 12);
        end else begin
          in_valid <= 1'b1;
          in_data  <= pending_chars.pop_front();
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (long_hold) begin
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (pending_chars.size() > TAIL_CHARS && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result word %h", out_data));
      end else begin
        out_word_t want;
        want = expected_results.pop_front();
        if (out_data.consumed !== want.consumed)
          report_mismatch($sformatf("consumed got %b want %b",
                                    out_data.consumed, want.consumed));
        if (out_data.scan_status !== want.scan_status)
          report_mismatch($sformatf("scan_status got %0d want %0d",
                                    out_data.scan_status, want.scan_status));
        if (out_data.give_back !== want.give_back)
          report_mismatch($sformatf("give_back got %b want %b",
                                    out_data.give_back, want.give_back));
      end
    end
  end

  initial begin
    while (chars_sent < HOLD_AFTER) @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    int target;
    // directed corner cases
    push_end(8'hFF);
    push_text("+x");
    push_text(".;");
    push_text("1..");
    push_text("..");
    push_text("+.");
    push_end(8'h00);
    push_char(8'h00);
    push_text("9e");
    push_char(8'hFF);
    push_text("0E-");
    push_end(8'h55);
    push_text("-5e+7");
    push_end(8'hAA);
    target = pending_chars.size() + RANDOM_CHARS;
    while (pending_chars.size() < target) begin
      if ($urandom_range(0, 4) != 0) begin
        push_literal();
      end else begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 7) == 0) push_end(8'($urandom_range(0, 255)));
          else push_char(8'($urandom_range(0, 255)));
        end
      end
    end
    while (!rst_n || pending_chars.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: filelist.f
src/fsp_pkg.sv
src/fsp_front.sv
src/fsp_back.sv
src/float_literal_prefix_scanner.sv
tb/float_literal_prefix_scanner_test.sv
